/* rtl/sirt_pkg.sv */
// Shared constants and types for the signed integer to radix text converter.
package sirt_pkg;

  localparam int VALUE_W        = 32;
  localparam int SYM_W          = 8;
  localparam int DIGIT_W        = 4;
  localparam int BASE_W         = 5;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_BASE       = 16;
  localparam int SYM_SLOTS      = 16;
  localparam int MAX_DIGITS     = 32;
  localparam int ADDR_W         = $clog2(MAX_DIGITS);
  localparam int COUNT_W        = ADDR_W + 1;
  localparam int BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
  localparam int STEP_W         = $clog2(DIV_CYCLES);

  localparam logic [BASE_W-1:0] BASE_LENGTH_RESET  = 5'd10;
  localparam logic [CFG_W-1:0]  SYMBOLS_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]  SYMBOLS_HIGH_RESET = 64'h4645444342413938;

  localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CHAR_DEL   = 8'h7F;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_LENGTH  = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

endpackage

/* rtl/sirt_if.sv */
// Stream interfaces for input numbers and output characters.
interface sirt_in_if;
  import sirt_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirt_out_if;
  import sirt_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

/* rtl/signed_integer_to_radix_text.sv */
// Signed 32-bit integer to text converter with a configurable symbol alphabet.
//
//   channel  dir  payload              transfer
//   num      in   value[31:0] signed   one number
//   txt      out  symbol[7:0], last    one character, last on the final one
//   cfg      in   cfg_index, cfg_data  one register write per cfg_write cycle
//
// A number is accepted, then divided digit by digit (four restoring steps per
// cycle on a 4-bit remainder); each character then takes a digit store read
// and an output register load, and a minus sign, if any, is loaded before them.
// Reset is synchronous; it restores the default alphabet "0123456789".
// A stalled txt holds the converter in place; the next number is taken
// while the final character still waits in the output register.
module signed_integer_to_radix_text (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sirt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sirt_pkg::CFG_W-1:0]     cfg_data,
  sirt_in_if.sink                        num,
  sirt_out_if.source                     txt
);
  import sirt_pkg::*;

  state_t state, state_next;

  logic [BASE_W-1:0]  base_length;
  logic [CFG_W-1:0]   symbols_low;
  logic [CFG_W-1:0]   symbols_high;

  logic [VALUE_W-1:0] mag, mag_next;
  logic [DIGIT_W-1:0] rem, rem_next;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_dec;
  logic               negative;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_digit;

  logic               txt_valid;
  logic [SYM_W-1:0]   txt_symbol;
  logic               txt_last;

  logic               alpha_ok;
  logic               in_take;
  logic               out_free;
  logic               div_last;
  logic               div_done;
  logic               load_sign;
  logic               load_sym;
  logic [2*CFG_W-1:0] sym_all;
  logic [SYM_W-1:0]   sym_arr [SYM_SLOTS];

  assign sym_all   = {symbols_high, symbols_low};
  assign count_dec = count - COUNT_W'(1);

  // Alphabet check: base 2 to 16, and no control, space, DEL, plus, minus or duplicate among the used slots.
  always_comb begin
    logic ok;
    ok = (base_length >= BASE_W'(2)) && (base_length <= BASE_W'(MAX_BASE));
    for (int i = 0; i < SYM_SLOTS; i++) begin
      sym_arr[i] = sym_all[i*SYM_W +: SYM_W];
    end
    for (int i = 0; i < SYM_SLOTS; i++) begin
      if (BASE_W'(i) < base_length) begin
        if (sym_arr[i] <= CHAR_SPACE || sym_arr[i] == CHAR_DEL ||
            sym_arr[i] == CHAR_PLUS || sym_arr[i] == CHAR_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < SYM_SLOTS; j++) begin
          if (BASE_W'(j) < base_length && sym_arr[j] == sym_arr[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
    alpha_ok = ok;
  end

  // Four restoring division steps per cycle.
  always_comb begin
    logic [BASE_W-1:0]         t;
    logic [DIGIT_W-1:0]        r;
    logic [BITS_PER_CYCLE-1:0] q;
    r = rem;
    q = '0;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      t = {r, mag[VALUE_W-1-k]};
      if (t >= base_length) begin
        t = t - base_length;
        q[BITS_PER_CYCLE-1-k] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
    mag_next = {mag[VALUE_W-BITS_PER_CYCLE-1:0], q};
  end

  always_comb begin
    out_free  = !txt_valid || txt.ready;
    in_take   = num.valid && num.ready;
    div_last  = (state == ST_DIVIDE) && (step == STEP_W'(DIV_CYCLES - 1));
    div_done  = (mag_next == '0) || (count == COUNT_W'(MAX_DIGITS - 1));
    load_sign = (state == ST_SIGN) && out_free;
    load_sym  = (state == ST_EMIT) && out_free;
    num.ready = (state == ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take && alpha_ok) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_last && div_done) state_next = negative ? ST_SIGN : ST_FETCH;
      end
      ST_SIGN: begin
        if (out_free) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_next = (count == COUNT_W'(1)) ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_length  <= BASE_LENGTH_RESET;
      symbols_low  <= SYMBOLS_LOW_RESET;
      symbols_high <= SYMBOLS_HIGH_RESET;
      count        <= '0;
      step         <= '0;
      rem          <= '0;
      mag          <= '0;
      negative     <= 1'b0;
      txt_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_BASE_LENGTH:  base_length  <= cfg_data[BASE_W-1:0];
          CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
          CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_IDLE && in_take) begin
        negative <= num.value[VALUE_W-1];
        mag      <= num.value[VALUE_W-1] ? (VALUE_W'(0) - num.value) : num.value;
        rem      <= '0;
        step     <= '0;
        count    <= '0;
      end else if (state == ST_DIVIDE) begin
        mag  <= mag_next;
        step <= step + STEP_W'(1);
        if (div_last) begin
          rem   <= '0;
          count <= count + COUNT_W'(1);
        end else begin
          rem <= rem_next;
        end
      end else if (load_sym) begin
        count <= count_dec;
      end
      if (load_sign || load_sym) begin
        txt_valid <= 1'b1;
      end else if (txt.ready) begin
        txt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      txt_symbol <= CHAR_MINUS;
      txt_last   <= 1'b0;
    end else if (load_sym) begin
      txt_symbol <= sym_all[{rd_digit, 3'b000} +: SYM_W];
      txt_last   <= (count == COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (div_last) begin
      digit_store[count[ADDR_W-1:0]] <= rem_next;
    end
    if (state == ST_FETCH) begin
      rd_digit <= digit_store[count_dec[ADDR_W-1:0]];
    end
  end

  assign txt.valid  = txt_valid;
  assign txt.symbol = txt_symbol;
  assign txt.last   = txt_last;

endmodule
